/* rtl/spdsup_pkg.sv */
// spdsup_pkg: shared types and constants of the speed limit supervisor
// no dependencies; imported by speed_limit_supervisor_core
`default_nettype none

package spdsup_pkg;

   localparam int SPEED_W   = 16;
   localparam int TIME_W    = 32;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int REQ_DW    = TIME_W + 4 * SPEED_W;
   localparam int RSP_DW    = 8;

   localparam logic [SPEED_W-1:0] DEADBAND_RST      = 16'd10;
   localparam logic [SPEED_W-1:0] MAX_WARN_TIME_RST = 16'd10;

   // register select bit (byte address bit 2)
   localparam logic CSR_SEL_DEADBAND      = 1'b0;
   localparam logic CSR_SEL_MAX_WARN_TIME = 1'b1;

   typedef enum logic [1:0] {
      ST_NORMAL   = 2'd0,
      ST_WARN_LO  = 2'd1,
      ST_WARN_HI  = 2'd2,
      ST_SHUTDOWN = 2'd3
   } state_type;

endpackage

`default_nettype wire

/* rtl/speed_limit_supervisor_core.sv */
// speed_limit_supervisor_core: classifies speed samples into normal, warn_low,
// warn_high or shutdown with hysteresis and a warn_high timeout
// depends on spdsup_pkg
`default_nettype none

// Each accepted sample yields exactly one result, in order. A sample goes
// into an input register, is classified by a few compares and one 32-bit
// wrapping subtraction against the held supervisor state, and the code lands
// in a result register. One sample per cycle is sustained while rsp_tready
// is held high, the rate being set by the single state update (last state and
// warn start time) that every sample makes.
// While the previous decision was warn_low the low limit is raised by the
// deadband (saturating at full scale); while it was warn_high the high limit
// is lowered by it (saturating at zero). A speed at or above the shutdown
// limit always gives shutdown, and warn_high held longer than max_warn_time
// seconds turns into shutdown; shutdown is not latched. Registers: deadband
// at byte address 0, max_warn_time at byte address 4 (address bit 2 selects);
// write them only while no sample is in flight.
module speed_limit_supervisor_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input samples
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   // timestamp, speed, low_limit, high_limit, shutdown_limit
   input  wire logic [spdsup_pkg::REQ_DW-1:0]  req_tdata,
   // results
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // state_code, zero filled
   output      logic [spdsup_pkg::RSP_DW-1:0]  rsp_tdata,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [spdsup_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [spdsup_pkg::CSR_DW-1:0]  csr_pwdata,
   output      logic [spdsup_pkg::CSR_DW-1:0]  csr_prdata,
   output      logic                           csr_pready
);
   import spdsup_pkg::*;

   // configuration registers
   logic [SPEED_W-1:0] deadband_ff;
   logic [SPEED_W-1:0] max_warn_time_ff;
   logic               csr_write;

   // input stage
   logic               s1_valid_ff;
   logic [TIME_W-1:0]  s1_timestamp_ff;
   logic [SPEED_W-1:0] s1_speed_ff;
   logic [SPEED_W-1:0] s1_low_ff;
   logic [SPEED_W-1:0] s1_high_ff;
   logic [SPEED_W-1:0] s1_stop_ff;

   // supervisor state
   state_type          last_state_ff;
   state_type          last_state_in;
   logic [TIME_W-1:0]  warn_start_ff;
   logic [TIME_W-1:0]  warn_start_in;

   // result stage
   logic               rsp_valid_ff;
   logic [1:0]         rsp_code_ff;
   logic [1:0]         rsp_code_in;

   logic               req_xfer;
   logic               advance;

   // effective limits and timeout
   logic [SPEED_W:0]   low_sum;
   logic [SPEED_W-1:0] low_eff;
   logic [SPEED_W-1:0] high_eff;
   logic [TIME_W-1:0]  elapsed;
   logic               timed_out;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff      <= DEADBAND_RST;
         max_warn_time_ff <= MAX_WARN_TIME_RST;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_SEL_DEADBAND:      deadband_ff      <= csr_pwdata[SPEED_W-1:0];
            CSR_SEL_MAX_WARN_TIME: max_warn_time_ff <= csr_pwdata[SPEED_W-1:0];
            default:               deadband_ff      <= deadband_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_SEL_DEADBAND:      csr_prdata = {{(CSR_DW-SPEED_W){1'b0}}, deadband_ff};
         CSR_SEL_MAX_WARN_TIME: csr_prdata = {{(CSR_DW-SPEED_W){1'b0}}, max_warn_time_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow
   // the input stage moves on whenever the result register is free or
   // being emptied in the same cycle
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_timestamp_ff <= req_tdata[TIME_W-1:0];
         s1_speed_ff     <= req_tdata[TIME_W+SPEED_W-1:TIME_W];
         s1_low_ff       <= req_tdata[TIME_W+2*SPEED_W-1:TIME_W+SPEED_W];
         s1_high_ff      <= req_tdata[TIME_W+3*SPEED_W-1:TIME_W+2*SPEED_W];
         s1_stop_ff      <= req_tdata[TIME_W+4*SPEED_W-1:TIME_W+3*SPEED_W];
      end
   end

   // ---------------------------------------------------------------- limits
   // hysteresis: raise the low limit after warn_low, lower the high limit
   // after warn_high, both saturating
   always_comb begin
      low_sum  = {1'b0, s1_low_ff} + {1'b0, deadband_ff};
      low_eff  = s1_low_ff;
      high_eff = s1_high_ff;
      if (last_state_ff == ST_WARN_LO) begin
         low_eff = low_sum[SPEED_W] ? {SPEED_W{1'b1}} : low_sum[SPEED_W-1:0];
      end
      if (last_state_ff == ST_WARN_HI) begin
         high_eff = (s1_high_ff > deadband_ff) ? (s1_high_ff - deadband_ff) : '0;
      end
   end

   // time in warn_high, wrapping modulo 2^32
   assign elapsed   = s1_timestamp_ff - warn_start_ff;
   assign timed_out = elapsed > {{(TIME_W-SPEED_W){1'b0}}, max_warn_time_ff};

   // ---------------------------------------------------------------- next state
   always_comb begin
      last_state_in = last_state_ff;
      warn_start_in = warn_start_ff;
      if (s1_speed_ff >= s1_stop_ff) begin
         last_state_in = ST_SHUTDOWN;
      end else if (s1_speed_ff >= high_eff) begin
         if (last_state_ff == ST_WARN_HI) begin
            // staying in warn_high keeps the start time
            last_state_in = timed_out ? ST_SHUTDOWN : ST_WARN_HI;
         end else begin
            last_state_in = ST_WARN_HI;
            warn_start_in = s1_timestamp_ff;
         end
      end else if (s1_speed_ff >= low_eff) begin
         last_state_in = ST_NORMAL;
      end else begin
         last_state_in = ST_WARN_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= ST_NORMAL;
         warn_start_ff <= '0;
      end else if (advance) begin
         last_state_ff <= last_state_in;
         warn_start_ff <= warn_start_in;
      end
   end

   // ---------------------------------------------------------------- outputs
   // the reported code is always the state just decided
   always_comb begin
      rsp_code_in = last_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff <= rsp_code_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-2){1'b0}}, rsp_code_ff};

   // ---------------------------------------------------------------- checks
   // the result transfer reports the state stored for the next sample
   a_code_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_code_ff == last_state_ff)
      else $error("result code differs from stored state");

   // entering warn_high records the sample's timestamp
   a_warn_start_taken: assert property (@(posedge clock) disable iff (reset)
      advance && last_state_ff != ST_WARN_HI && last_state_in == ST_WARN_HI
      |=> warn_start_ff == $past(s1_timestamp_ff))
      else $error("warn start time not recorded");

   // a speed at or above the shutdown limit always reports shutdown
   a_shutdown_limit: assert property (@(posedge clock) disable iff (reset)
      advance && s1_speed_ff >= s1_stop_ff |=> rsp_code_ff == ST_SHUTDOWN)
      else $error("shutdown limit not honoured");

   // a held sample is neither lost nor overwritten
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_timestamp_ff)
         && $stable(s1_speed_ff))
      else $error("stalled sample lost");

endmodule

`default_nettype wire
